### rtl/reliable_udp_receive_sequencer_assert.svh
// assertion macros shared by the receive sequencer modules
`ifndef RELIABLE_UDP_RECEIVE_SEQUENCER_ASSERT_SVH
`define RELIABLE_UDP_RECEIVE_SEQUENCER_ASSERT_SVH

// property checked at every clock edge outside reset
`define RUSQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence checked in the cycle after the antecedent
`define RUSQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/rusq_pkg.sv
// types and constants of the receive sequencer
`default_nettype none

package rusq_pkg;

    // width of the window slot index
    localparam int SLOT_W = 5;

    typedef enum logic [1:0] {
        KIND_DATA      = 2'd0,
        KIND_RESET     = 2'd1,
        KIND_ACK_RESET = 2'd2,
        KIND_PING      = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_DELIVERED     = 3'd0,
        ST_STORED        = 3'd1,
        ST_DUPLICATE     = 3'd2,
        ST_OUT_OF_WINDOW = 3'd3,
        ST_RESET_REQUEST = 3'd4,
        ST_CHANNEL_RESET = 3'd5,
        ST_PING          = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        ACK_NONE  = 2'd0,
        ACK_DATA  = 2'd1,
        ACK_RESET = 2'd2,
        ACK_PING  = 2'd3
    } t_ack;

    // classified item handed from the front to the back
    typedef struct packed {
        t_kind              kind;
        logic [15:0]        id;
        logic [15:0]        handle;
        logic [SLOT_W-1:0]  slot;
    } t_item;

    typedef struct packed {
        t_status     status;
        t_ack        ack;
        logic [15:0] handle;
        logic [15:0] id;
        logic [15:0] next_expected;
        logic [15:0] outrun;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

### rtl/rusq_front.sv
// front end: accepts items, reduces the id and finds its window slot
`default_nettype none

module rusq_front #(
    parameter int ID_LIMIT = 65536,
    parameter int WINDOW   = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_operation,
    input  logic [15:0]          i_packet_id,
    input  logic [15:0]          i_payload_handle,
    output logic                 o_push,
    output rusq_pkg::t_item      o_item,
    input  logic                 i_full
);

    localparam int STAGES = 5;
    // reciprocals for the remainder by multiplication, quotient low by at most one
    localparam longint unsigned ML = 64'h1_0000_0000 / ID_LIMIT;
    localparam longint unsigned MW = 64'h1_0000_0000 / WINDOW;

    typedef struct packed {
        rusq_pkg::t_kind kind;
        logic [15:0]     id;
        logic [15:0]     handle;
        logic [17:0]     num;
    } t_stage;

    t_stage             r_stg [STAGES];
    logic [STAGES-1:0]  r_vld;

    logic        w_en;
    logic [47:0] w_prod_l;
    logic [47:0] w_prod_w;
    logic [33:0] w_back_l;
    logic [33:0] w_back_w;
    logic [17:0] w_red;
    logic [5:0]  w_slot;

    assign w_en    = !r_vld[STAGES-1] || !i_full;
    assign o_ready = w_en;
    assign o_push  = r_vld[STAGES-1] && !i_full;

    assign w_prod_l = 48'(i_packet_id) * 48'(ML);
    assign w_back_l = 34'(r_stg[0].num) * 34'(ID_LIMIT);
    assign w_red    = (r_stg[1].num >= 18'(ID_LIMIT)) ? r_stg[1].num - 18'(ID_LIMIT)
                                                      : r_stg[1].num;
    assign w_prod_w = 48'(r_stg[2].id) * 48'(MW);
    assign w_back_w = 34'(r_stg[3].num) * 34'(WINDOW);
    assign w_slot   = (r_stg[4].num[5:0] >= 6'(WINDOW)) ? r_stg[4].num[5:0] - 6'(WINDOW)
                                                        : r_stg[4].num[5:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // quotient estimate by the id limit
            r_stg[0].kind   <= rusq_pkg::t_kind'(i_operation);
            r_stg[0].id     <= i_packet_id;
            r_stg[0].handle <= i_payload_handle;
            r_stg[0].num    <= 18'(w_prod_l[47:32]);
            // remainder below twice the limit
            r_stg[1].kind   <= r_stg[0].kind;
            r_stg[1].id     <= r_stg[0].id;
            r_stg[1].handle <= r_stg[0].handle;
            r_stg[1].num    <= {2'b00, r_stg[0].id} - w_back_l[17:0];
            // reduced id
            r_stg[2].kind   <= r_stg[1].kind;
            r_stg[2].id     <= w_red[15:0];
            r_stg[2].handle <= r_stg[1].handle;
            r_stg[2].num    <= '0;
            // quotient estimate by the window
            r_stg[3].kind   <= r_stg[2].kind;
            r_stg[3].id     <= r_stg[2].id;
            r_stg[3].handle <= r_stg[2].handle;
            r_stg[3].num    <= 18'(w_prod_w[47:32]);
            // slot below twice the window
            r_stg[4].kind   <= r_stg[3].kind;
            r_stg[4].id     <= r_stg[3].id;
            r_stg[4].handle <= r_stg[3].handle;
            r_stg[4].num    <= {2'b00, r_stg[3].id} - w_back_w[17:0];
        end
    end

    assign o_item.kind   = r_stg[STAGES-1].kind;
    assign o_item.id     = r_stg[STAGES-1].id;
    assign o_item.handle = r_stg[STAGES-1].handle;
    assign o_item.slot   = w_slot[rusq_pkg::SLOT_W-1:0];

endmodule

`default_nettype wire

### rtl/rusq_queue.sv
// two-entry queue between the front and the back
`default_nettype none

`include "reliable_udp_receive_sequencer_assert.svh"

module rusq_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rusq_pkg::t_item  i_item,
    output logic             o_full,
    input  logic             i_pop,
    output rusq_pkg::t_item  o_item,
    output logic             o_empty
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    rusq_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;

    assign o_full  = r_count == (PTR_W + 1)'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `RUSQ_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= (PTR_W + 1)'(DEPTH), "queue overfilled")
    `RUSQ_ASSERT(a_no_push_full, i_clk, i_rst_n, i_push |-> !o_full, "push into full queue")
    `RUSQ_ASSERT(a_no_pop_empty, i_clk, i_rst_n, i_pop |-> !o_empty, "pop from empty queue")

endmodule

`default_nettype wire

### rtl/rusq_back.sv
// back end: sequence state, reorder window, drain of stored runs, result register
`default_nettype none

`include "reliable_udp_receive_sequencer_assert.svh"

module rusq_back #(
    parameter int ID_LIMIT = 65536,
    parameter int WINDOW   = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  rusq_pkg::t_item   i_item,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output rusq_pkg::t_result o_result
);

    localparam int IDX_W = $clog2(WINDOW);
    localparam int CNT_W = IDX_W + 1;

    typedef enum logic [1:0] {
        B_IDLE,
        B_EVAL,
        B_DRAIN
    } t_state;

    t_state            r_state, n_state;
    rusq_pkg::t_item   r_cur, n_cur;
    logic [16:0]       r_diff, n_diff;
    logic [15:0]       r_expected, n_expected;
    logic [IDX_W-1:0]  r_exp_slot, n_exp_slot;
    logic [WINDOW-1:0] r_slot_valid, n_slot_valid;
    logic [15:0]       r_outrun, n_outrun;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_valid, n_out_valid;
    rusq_pkg::t_result r_out, n_out;

    logic [15:0]       r_handle_mem [WINDOW];
    logic [15:0]       r_rd_handle;

    logic              w_out_free;
    logic              w_clear;
    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_slot;
    logic [16:0]       w_inc;
    logic              w_wrap;
    logic [15:0]       w_nx;
    logic [IDX_W-1:0]  w_nxs;
    logic [16:0]       w_dist;
    logic [IDX_W-1:0]  w_cur_slot;
    logic [CNT_W-1:0]  w_cnt_next;

    // successor id skips zero across the wrap
    assign w_inc  = {1'b0, r_expected} + 17'd1;
    assign w_wrap = w_inc == 17'(ID_LIMIT);
    assign w_nx   = w_wrap ? 16'd1 : w_inc[15:0];
    assign w_nxs  = w_wrap ? IDX_W'(1)
                  : (r_exp_slot == IDX_W'(WINDOW - 1)) ? '0 : r_exp_slot + 1'b1;

    assign w_dist     = r_diff[16] ? r_diff + 17'(ID_LIMIT) : r_diff;
    assign w_cur_slot = r_cur.slot[IDX_W-1:0];
    assign w_cnt_next = r_cnt + 1'b1;
    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_diff       = r_diff;
        n_expected   = r_expected;
        n_exp_slot   = r_exp_slot;
        n_slot_valid = r_slot_valid;
        n_outrun     = r_outrun;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !i_ready;
        n_out        = r_out;
        o_pop        = 1'b0;
        w_clear      = 1'b0;
        w_wr_en      = 1'b0;
        w_wr_slot    = w_cur_slot;

        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_cur   = i_item;
                    n_diff  = {1'b0, i_item.id} - {1'b0, r_expected};
                    n_state = B_EVAL;
                end
            end
            B_EVAL: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_state       = B_IDLE;
                    n_out.status  = rusq_pkg::ST_DUPLICATE;
                    n_out.ack     = rusq_pkg::ACK_DATA;
                    n_out.handle  = 16'd0;
                    n_out.id      = r_cur.id;
                    n_out.last    = 1'b1;
                    case (r_cur.kind)
                        rusq_pkg::KIND_RESET, rusq_pkg::KIND_ACK_RESET: begin
                            w_clear       = 1'b1;
                            n_out.status  = rusq_pkg::ST_CHANNEL_RESET;
                            n_out.ack     = (r_cur.kind == rusq_pkg::KIND_RESET)
                                          ? rusq_pkg::ACK_RESET : rusq_pkg::ACK_NONE;
                            n_expected    = 16'd0;
                            n_exp_slot    = '0;
                            n_slot_valid  = '0;
                            n_outrun      = 16'd0;
                        end
                        rusq_pkg::KIND_PING: begin
                            n_out.status = rusq_pkg::ST_PING;
                            n_out.ack    = rusq_pkg::ACK_PING;
                            n_outrun     = 16'd0;
                        end
                        rusq_pkg::KIND_DATA: begin
                            if (r_expected == 16'd0 && r_cur.id != 16'd0) begin
                                n_out.status = rusq_pkg::ST_RESET_REQUEST;
                            end else if (r_cur.id == r_expected) begin
                                n_out.status = rusq_pkg::ST_DELIVERED;
                                n_out.handle = r_cur.handle;
                                n_outrun     = 16'd0;
                                n_expected   = w_nx;
                                n_exp_slot   = w_nxs;
                                n_cnt        = '0;
                                if (r_slot_valid[w_nxs]) begin
                                    n_out.last = 1'b0;
                                    n_state    = B_DRAIN;
                                end
                            end else if (r_cur.id == 16'd0) begin
                                n_out.status = rusq_pkg::ST_RESET_REQUEST;
                            end else if (w_dist < 17'(WINDOW)) begin
                                if (!r_slot_valid[w_cur_slot]) begin
                                    n_out.status             = rusq_pkg::ST_STORED;
                                    n_out.handle             = r_cur.handle;
                                    n_slot_valid[w_cur_slot] = 1'b1;
                                    w_wr_en                  = 1'b1;
                                    n_outrun = (r_outrun == 16'hFFFF) ? r_outrun
                                                                      : r_outrun + 16'd1;
                                end
                            end else if (w_dist < 17'(ID_LIMIT / 2)) begin
                                n_out.status = rusq_pkg::ST_OUT_OF_WINDOW;
                            end
                        end
                        default: ;
                    endcase
                    n_out.next_expected = n_expected;
                    n_out.outrun        = n_outrun;
                end
            end
            B_DRAIN: begin
                if (w_out_free) begin
                    n_out_valid              = 1'b1;
                    n_out.status             = rusq_pkg::ST_DELIVERED;
                    n_out.ack                = rusq_pkg::ACK_NONE;
                    n_out.handle             = r_rd_handle;
                    n_out.id                 = r_expected;
                    n_slot_valid[r_exp_slot] = 1'b0;
                    n_expected               = w_nx;
                    n_exp_slot               = w_nxs;
                    n_cnt                    = w_cnt_next;
                    // a run follows one delivery by at most one window less one
                    if (n_slot_valid[w_nxs] && w_cnt_next < CNT_W'(WINDOW - 1)) begin
                        n_out.last = 1'b0;
                    end else begin
                        n_out.last = 1'b1;
                        n_state    = B_IDLE;
                    end
                    n_out.next_expected = n_expected;
                    n_out.outrun        = r_outrun;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // handle store, read registered at the next expected slot to be ready for the drain
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_handle_mem[w_wr_slot] <= r_cur.handle;
        end
        r_rd_handle <= r_handle_mem[n_exp_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= B_IDLE;
            r_expected   <= 16'd0;
            r_exp_slot   <= '0;
            r_slot_valid <= '0;
            r_outrun     <= 16'd0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cur        <= n_cur;
            r_diff       <= n_diff;
            r_expected   <= n_expected;
            r_exp_slot   <= n_exp_slot;
            r_slot_valid <= n_slot_valid;
            r_outrun     <= n_outrun;
            r_cnt        <= n_cnt;
            r_out_valid  <= n_out_valid;
            r_out        <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    `RUSQ_ASSERT(a_drain_has_entry, i_clk, i_rst_n, (r_state == B_DRAIN) |-> r_slot_valid[r_exp_slot], "drain without stored entry")
    `RUSQ_ASSERT(a_expected_bound, i_clk, i_rst_n, r_expected <= 16'(ID_LIMIT - 1), "expected id beyond limit")
    `RUSQ_ASSERT_NEXT(a_clear_all, i_clk, i_rst_n, w_clear, (r_expected == 16'd0) && (r_slot_valid == '0) && (r_outrun == 16'd0), "channel reset left state behind")

endmodule

`default_nettype wire

### rtl/reliable_udp_receive_sequencer.sv
// Receive sequencer of a reliable datagram channel with a reorder window.
// Input channel (i_valid/o_ready) takes one packet event per item: operation,
// packet id and payload handle. Output channel (o_valid/i_ready) gives the
// result items an event causes; o_last marks the final one of each event.
// A data packet in order is delivered and then the run of stored packets that
// follows it; packets a little ahead are parked in window slots.
// An item passes the 5 front stages for the id and slot reduction, the queue,
// and then lookup and decision in the back before its first result appears.
// The back handles one event at a time in its lookup and decide steps, then
// drains each stored packet of the run, one per cycle while i_ready is high.
// Reset (i_rst_n low, synchronous) empties the queue and window and sets the
// expected id to 0; no clearing pass follows, items are taken right after.
// If i_ready stays low the result register holds, the back stops, the queue
// fills and o_ready falls once an item waits in the last front stage.
`default_nettype none

module reliable_udp_receive_sequencer #(
    parameter int ID_LIMIT = 65536,
    parameter int WINDOW   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [15:0] i_packet_id,
    input  logic [15:0] i_payload_handle,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [1:0]  o_ack_kind,
    output logic [15:0] o_delivered_handle,
    output logic [15:0] o_delivered_id,
    output logic [15:0] o_next_expected,
    output logic [15:0] o_outrun_total,
    output logic        o_last
);

    rusq_pkg::t_item   w_push_item;
    rusq_pkg::t_item   w_pop_item;
    rusq_pkg::t_result w_result;
    logic              w_push;
    logic              w_full;
    logic              w_pop;
    logic              w_empty;

    rusq_front #(
        .ID_LIMIT (ID_LIMIT),
        .WINDOW   (WINDOW)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_operation      (i_operation),
        .i_packet_id      (i_packet_id),
        .i_payload_handle (i_payload_handle),
        .o_push           (w_push),
        .o_item           (w_push_item),
        .i_full           (w_full)
    );

    rusq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_item  (w_pop_item),
        .o_empty (w_empty)
    );

    rusq_back #(
        .ID_LIMIT (ID_LIMIT),
        .WINDOW   (WINDOW)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (w_empty),
        .i_item   (w_pop_item),
        .o_pop    (w_pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (w_result)
    );

    assign o_status           = w_result.status;
    assign o_ack_kind         = w_result.ack;
    assign o_delivered_handle = w_result.handle;
    assign o_delivered_id     = w_result.id;
    assign o_next_expected    = w_result.next_expected;
    assign o_outrun_total     = w_result.outrun;
    assign o_last             = w_result.last;

endmodule

`default_nettype wire

### bench/tb_top.sv
// self-checking bench for the receive sequencer: tracks order, checks every result item
`default_nettype none

module tb_top;

    localparam int SLOTS       = 32;
    localparam int ID_SPAN     = 65536;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 40;
    localparam int RANDOM_ITEMS = 260;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_operation = rusq_pkg::KIND_DATA;
    logic [15:0] i_packet_id = '0;
    logic [15:0] i_payload_handle = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_status;
    logic [1:0]  o_ack_kind;
    logic [15:0] o_delivered_handle;
    logic [15:0] o_delivered_id;
    logic [15:0] o_next_expected;
    logic [15:0] o_outrun_total;
    logic        o_last;

    // idling controls shared between the driving processes
    bit tx_fast = 1'b0;
    bit rx_fast = 1'b0;
    bit rx_hold = 1'b0;
    int sent = 0;

    always #6 i_clk = ~i_clk;

    reliable_udp_receive_sequencer #(
        .ID_LIMIT(ID_SPAN),
        .WINDOW  (SLOTS)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_operation       (i_operation),
        .i_packet_id       (i_packet_id),
        .i_payload_handle  (i_payload_handle),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_status          (o_status),
        .o_ack_kind        (o_ack_kind),
        .o_delivered_handle(o_delivered_handle),
        .o_delivered_id    (o_delivered_id),
        .o_next_expected   (o_next_expected),
        .o_outrun_total    (o_outrun_total),
        .o_last            (o_last)
    );

    // sequence ids wrap and never come back to zero
    function automatic logic [15:0] seq_after(logic [15:0] v);
        logic [15:0] n;
        n = v + 16'd1;
        if (n == 16'd0) n = 16'd1;
        return n;
    endfunction

    class order_tracker;
        logic [15:0]       exp_id;
        logic [15:0]       outrun;
        bit                parked[SLOTS];
        logic [15:0]       parked_handle[SLOTS];
        rusq_pkg::t_result results_due[$];
        int                failures;

        function new();
            clear_state();
            failures = 0;
        endfunction

        function void clear_state();
            exp_id = '0;
            outrun = '0;
            foreach (parked[k]) parked[k] = 1'b0;
        endfunction

        function void add_due(rusq_pkg::t_status st, rusq_pkg::t_ack ack,
                              logic [15:0] handle, logic [15:0] id);
            rusq_pkg::t_result r;
            r.status        = st;
            r.ack           = ack;
            r.handle        = handle;
            r.id            = id;
            r.next_expected = exp_id;
            r.outrun        = outrun;
            r.last          = 1'b0;
            results_due.push_back(r);
        endfunction

        function void take_packet(rusq_pkg::t_kind op, logic [15:0] pid, logic [15:0] handle);
            logic [15:0]       ahead;
            logic [15:0]       got;
            int                s;
            rusq_pkg::t_result r;
            case (op)
                rusq_pkg::KIND_RESET, rusq_pkg::KIND_ACK_RESET: begin
                    clear_state();
                    add_due(rusq_pkg::ST_CHANNEL_RESET,
                            (op == rusq_pkg::KIND_RESET) ? rusq_pkg::ACK_RESET
                                                         : rusq_pkg::ACK_NONE,
                            '0, pid);
                end
                rusq_pkg::KIND_PING: begin
                    outrun = '0;
                    add_due(rusq_pkg::ST_PING, rusq_pkg::ACK_PING, '0, pid);
                end
                default: begin
                    ahead = pid - exp_id;
                    if (exp_id == 16'd0 && pid != 16'd0) begin
                        add_due(rusq_pkg::ST_RESET_REQUEST, rusq_pkg::ACK_DATA, '0, pid);
                    end else if (pid == exp_id) begin
                        outrun = '0;
                        exp_id = seq_after(exp_id);
                        add_due(rusq_pkg::ST_DELIVERED, rusq_pkg::ACK_DATA, handle, pid);
                        // drain the run of parked packets that now follow in order
                        for (int k = 0; k < SLOTS - 1; k++) begin
                            s = exp_id % SLOTS;
                            if (!parked[s]) break;
                            parked[s] = 1'b0;
                            got = exp_id;
                            exp_id = seq_after(exp_id);
                            add_due(rusq_pkg::ST_DELIVERED, rusq_pkg::ACK_NONE,
                                    parked_handle[s], got);
                        end
                    end else if (pid == 16'd0) begin
                        add_due(rusq_pkg::ST_RESET_REQUEST, rusq_pkg::ACK_DATA, '0, pid);
                    end else if (ahead < SLOTS) begin
                        s = pid % SLOTS;
                        if (parked[s]) begin
                            add_due(rusq_pkg::ST_DUPLICATE, rusq_pkg::ACK_DATA, '0, pid);
                        end else begin
                            parked[s] = 1'b1;
                            parked_handle[s] = handle;
                            if (outrun != 16'hFFFF) outrun = outrun + 16'd1;
                            add_due(rusq_pkg::ST_STORED, rusq_pkg::ACK_DATA, handle, pid);
                        end
                    end else if (ahead < ID_SPAN / 2) begin
                        add_due(rusq_pkg::ST_OUT_OF_WINDOW, rusq_pkg::ACK_DATA, '0, pid);
                    end else begin
                        add_due(rusq_pkg::ST_DUPLICATE, rusq_pkg::ACK_DATA, '0, pid);
                    end
                end
            endcase
            r = results_due.pop_back();
            r.last = 1'b1;
            results_due.push_back(r);
        endfunction

        function void match_result(rusq_pkg::t_result seen);
            rusq_pkg::t_result want;
            if (results_due.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result item: status %0d id %0d handle %0d",
                             seen.status, seen.id, seen.handle);
                return;
            end
            want = results_due.pop_front();
            if (seen.status !== want.status || seen.ack !== want.ack ||
                seen.handle !== want.handle || seen.id !== want.id ||
                seen.next_expected !== want.next_expected ||
                seen.outrun !== want.outrun || seen.last !== want.last) begin
                failures++;
                if (failures <= 10) begin
                    $display("mismatch: expected st %0d ack %0d hdl %0d id %0d nxt %0d run %0d last %0d",
                             want.status, want.ack, want.handle, want.id,
                             want.next_expected, want.outrun, want.last);
                    $display("          actual   st %0d ack %0d hdl %0d id %0d nxt %0d run %0d last %0d",
                             seen.status, seen.ack, seen.handle, seen.id,
                             seen.next_expected, seen.outrun, seen.last);
                end
            end
        endfunction
    endclass

    order_tracker tracker;

    task automatic send_packet(rusq_pkg::t_kind op, logic [15:0] pid, logic [15:0] handle);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_operation      <= op;
        i_packet_id      <= pid;
        i_payload_handle <= handle;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        tracker.take_packet(op, pid, handle);
        sent++;
    endtask

    task automatic send_data(logic [15:0] pid);
        send_packet(rusq_pkg::KIND_DATA, pid, 16'($urandom_range(0, 65535)));
    endtask

    // a run of span consecutive ids in shuffled order
    task automatic send_run(int span, bit head_last);
        logic [15:0] tail[SLOTS];
        logic [15:0] head;
        logic [15:0] v;
        logic [15:0] t;
        int          j;
        int          pos;
        int          idx;
        if (tracker.exp_id == 16'd0) send_data(16'd0);
        head = tracker.exp_id;
        v = seq_after(head);
        for (int k = 0; k < span - 1; k++) begin
            tail[k] = v;
            v = seq_after(v);
        end
        for (int k = span - 2; k > 0; k--) begin
            j = $urandom_range(0, k);
            t = tail[k];
            tail[k] = tail[j];
            tail[j] = t;
        end
        pos = head_last ? span - 1 : $urandom_range(0, span - 1);
        idx = 0;
        for (int k = 0; k < span; k++) begin
            if (k == pos) begin
                send_data(head);
            end else begin
                send_data(tail[idx]);
                idx++;
            end
            // occasional resend of the same id
            if ($urandom_range(0, 11) == 0) send_data(i_packet_id);
        end
    endtask

    task automatic send_noise();
        logic [15:0]     pid;
        rusq_pkg::t_kind op;
        case ($urandom_range(0, 9))
            0, 1:    pid = 16'($urandom_range(0, 65535));
            2:       pid = tracker.exp_id + 16'($urandom_range(1, 31));
            3:       pid = tracker.exp_id + 16'($urandom_range(32, 40));
            4:       pid = tracker.exp_id - 16'($urandom_range(1, 5));
            5:       pid = 16'd0;
            6:       pid = 16'hFFFF;
            7:       pid = tracker.exp_id + 16'h7FFF + 16'($urandom_range(0, 1));
            default: pid = tracker.exp_id;
        endcase
        if ($urandom_range(0, 19) < 3) op = rusq_pkg::t_kind'($urandom_range(1, 3));
        else op = rusq_pkg::KIND_DATA;
        send_packet(op, pid, 16'($urandom_range(0, 65535)));
    endtask

    // result side
    initial begin
        int                gap;
        rusq_pkg::t_result seen;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (rx_hold) begin
                gap = HOLD_CYCLES;
                rx_hold = 1'b0;
            end else begin
                gap = rx_fast ? 0 : $urandom_range(0, 12);
            end
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            seen.status        = rusq_pkg::t_status'(o_status);
            seen.ack           = rusq_pkg::t_ack'(o_ack_kind);
            seen.handle        = o_delivered_handle;
            seen.id            = o_delivered_id;
            seen.next_expected = o_next_expected;
            seen.outrun        = o_outrun_total;
            seen.last          = o_last;
            tracker.match_result(seen);
        end
    end

    // watchdog on cycles with no item moving on either side
    initial begin
        int idle;
        idle = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle = 0;
            else idle++;
        end
        $display("FAIL");
        $finish;
    end

    initial begin
        int  first_random;
        int  pick;
        bit  hold_done;
        bit  pause_done;
        tracker = new();
        hold_done = 1'b0;
        pause_done = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: each decision branch and the id edges
        send_packet(rusq_pkg::KIND_DATA, 16'd5, 16'h1111);        // nonzero id while expecting zero
        send_packet(rusq_pkg::KIND_PING, 16'd9, 16'h2222);
        send_packet(rusq_pkg::KIND_ACK_RESET, 16'hFFFF, 16'hFFFF);
        send_packet(rusq_pkg::KIND_RESET, 16'h1234, 16'd0);
        send_packet(rusq_pkg::KIND_DATA, 16'd0, 16'hFFFF);
        send_packet(rusq_pkg::KIND_DATA, 16'd3, 16'd0);
        send_packet(rusq_pkg::KIND_DATA, 16'd2, 16'hAAAA);
        send_packet(rusq_pkg::KIND_DATA, 16'd3, 16'h5555);        // slot already taken
        send_packet(rusq_pkg::KIND_PING, 16'd0, 16'd7);
        send_packet(rusq_pkg::KIND_DATA, 16'd1, 16'd1);           // delivers and drains two
        send_packet(rusq_pkg::KIND_DATA, 16'd36, 16'h0F0F);       // one past the window
        send_packet(rusq_pkg::KIND_DATA, 16'd35, 16'hF0F0);       // last slot of the window
        send_packet(rusq_pkg::KIND_DATA, 16'd0, 16'h3333);        // zero id mid-stream
        send_packet(rusq_pkg::KIND_DATA, 16'd2, 16'h4444);        // behind
        send_packet(rusq_pkg::KIND_DATA, 16'hFFFF, 16'h6666);
        send_packet(rusq_pkg::KIND_DATA, 16'h8003, 16'h7777);     // farthest still ahead
        send_packet(rusq_pkg::KIND_DATA, 16'h8004, 16'h8888);     // half way round counts as behind
        send_packet(rusq_pkg::KIND_RESET, 16'd0, 16'h9999);
        send_packet(rusq_pkg::KIND_DATA, 16'd35, 16'h5A5A);       // parked entry is gone after reset

        first_random = sent;
        // full window parked first so one delivery drains the longest run
        send_run(SLOTS, 1'b1);
        while (sent - first_random < RANDOM_ITEMS) begin
            tx_fast = ($urandom_range(0, 3) == 0);
            rx_fast = ($urandom_range(0, 3) == 0);
            if (!hold_done && sent - first_random > 70) begin
                // stall the results while the input keeps coming
                hold_done = 1'b1;
                rx_hold = 1'b1;
                tx_fast = 1'b1;
                send_run(SLOTS, 1'b0);
                send_run(SLOTS, 1'b1);
            end else if (!pause_done && sent - first_random > 180) begin
                pause_done = 1'b1;
                i_valid <= 1'b0;
                while (tracker.results_due.size() != 0) @(posedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_packet($urandom_range(0, 1) ? rusq_pkg::KIND_RESET
                                                 : rusq_pkg::KIND_ACK_RESET,
                            16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
                send_data(16'd0);
            end else if (pick < 60) begin
                if ($urandom_range(0, 9) == 0) send_run(SLOTS, 1'($urandom_range(0, 1)));
                else send_run($urandom_range(1, 8), 1'($urandom_range(0, 1)));
            end else if (pick < 75) begin
                repeat ($urandom_range(1, 6)) send_data(tracker.exp_id);
            end else begin
                send_noise();
            end
        end

        i_valid <= 1'b0;
        while (tracker.results_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (tracker.failures == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
